[hdl/bbf_pkg.sv]
`timescale 1ns / 1ps

package bbf_pkg;

  // Defaults for the top-level parameters
  localparam int SOURCE_COUNT    = 16;
  localparam int BUS_BYTES       = 8;
  localparam int BEAT_COUNT_BITS = 16;
  localparam int QUEUE_DEPTH     = 2;

  // Fixed field widths
  localparam int ADDR_BITS = 32;
  localparam int BEATS_W   = 16;
  localparam int SRC_ID_W  = 4;
  localparam int SIZE_W    = 4;
  localparam int CFG_W     = 4;

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef logic [CFG_W-1:0] cfg_t;

  typedef struct packed {
    logic                 cmd_valid;
    logic [ADDR_BITS-1:0] cmd_address;
    logic [BEATS_W-1:0]   cmd_beats;
    logic                 req_ready;
    logic                 pause;
    logic                 resp_last_done;
    logic [SRC_ID_W-1:0]  resp_source;
  } item_t;

  typedef struct packed {
    logic                 req_valid;
    logic [ADDR_BITS-1:0] req_address;
    logic [SRC_ID_W-1:0]  req_source;
    logic [SIZE_W-1:0]    req_size_log2;
    logic                 cmd_ready;
  } result_t;

  // Classified tick, front to back
  typedef struct packed {
    logic                 issue;      // command offered and not paused
    logic                 req_ready;
    logic [ADDR_BITS-1:0] cmd_address;
    logic [BEATS_W-1:0]   cmd_beats;
    logic                 rel_valid;  // response frees an in-range ID
    logic [SRC_ID_W-1:0]  rel_id;
  } ent_t;

endpackage

[hdl/bbf_chan_if.sv]
`timescale 1ns / 1ps

interface bbf_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/bus_read_burst_fetcher_core.sv]
`timescale 1ns / 1ps

// Burst read-request issuer. Each word on item_i is one bus tick (offered command, request
// ready, pause, response completion); each word on result_o is the request presented that
// tick plus the command acknowledge. One word is taken per clock when result_o keeps up; a
// taken word goes into the queue, and when the back pops it, the back's state update of lowest
// free source and beat/byte offset loads the output register, from which it leaves on result_o.
// A stalled result_o fills the output register and the QUEUE_DEPTH-word queue before item_i
// is held off.
// cfg_i is always ready and sets log2 beats per burst; write it only while idle.
module bus_read_burst_fetcher_core #(
  parameter int SOURCE_COUNT    = bbf_pkg::SOURCE_COUNT,
  parameter int BUS_BYTES       = bbf_pkg::BUS_BYTES,
  parameter int BEAT_COUNT_BITS = bbf_pkg::BEAT_COUNT_BITS,
  parameter int QUEUE_DEPTH     = bbf_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bbf_chan_if.sink          item_i,
  bbf_chan_if.source        result_o,
  bbf_chan_if.sink          cfg_i
);

  logic          q_push, q_ready, q_valid, q_pop;
  bbf_pkg::ent_t q_wdata, q_rdata;

  assign cfg_i.ready = 1'b1;

  bbf_front #(
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_front (
    .item_valid_i (item_i.valid),
    .item_data_i  (item_i.data),
    .item_ready_o (item_i.ready),
    .q_ready_i    (q_ready),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  bbf_queue #(
    .entry_t (bbf_pkg::ent_t),
    .DEPTH   (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_data_i  (q_wdata),
    .push_ready_o (q_ready),
    .pop_valid_o  (q_valid),
    .pop_data_o   (q_rdata),
    .pop_i        (q_pop)
  );

  bbf_back #(
    .SOURCE_COUNT    (SOURCE_COUNT),
    .BUS_BYTES       (BUS_BYTES),
    .BEAT_COUNT_BITS (BEAT_COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data),
    .out_ready_i (result_o.ready)
  );

endmodule

[hdl/bbf_front.sv]
`timescale 1ns / 1ps

module bbf_front #(
  parameter int SOURCE_COUNT = bbf_pkg::SOURCE_COUNT
) (
  input  logic           item_valid_i,
  input  bbf_pkg::item_t item_data_i,
  output logic           item_ready_o,
  input  logic           q_ready_i,
  output logic           q_push_o,
  output bbf_pkg::ent_t  q_data_o
);

  localparam int CW = bbf_pkg::SRC_ID_W + 3;

  logic src_in_range;

  assign src_in_range = CW'(item_data_i.resp_source) < CW'(SOURCE_COUNT);

  assign item_ready_o = q_ready_i;
  assign q_push_o     = item_valid_i && q_ready_i;

  always_comb begin
    q_data_o.issue       = item_data_i.cmd_valid && !item_data_i.pause;
    q_data_o.req_ready   = item_data_i.req_ready;
    q_data_o.cmd_address = item_data_i.cmd_address;
    q_data_o.cmd_beats   = item_data_i.cmd_beats;
    q_data_o.rel_valid   = item_data_i.resp_last_done && src_in_range;
    q_data_o.rel_id      = item_data_i.resp_source;
  end

endmodule

[hdl/bbf_queue.sv]
`timescale 1ns / 1ps

// Small FIFO between front and back; DEPTH of at least 2.
module bbf_queue #(
  parameter type entry_t = logic,
  parameter int  DEPTH   = bbf_pkg::QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   push_ready_o,
  output logic   pop_valid_o,
  output entry_t pop_data_o,
  input  logic   pop_i
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

[hdl/bbf_back.sv]
`timescale 1ns / 1ps

module bbf_back #(
  parameter int SOURCE_COUNT    = bbf_pkg::SOURCE_COUNT,
  parameter int BUS_BYTES       = bbf_pkg::BUS_BYTES,
  parameter int BEAT_COUNT_BITS = bbf_pkg::BEAT_COUNT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  bbf_pkg::cfg_t    cfg_data_i,
  input  logic             q_valid_i,
  input  bbf_pkg::ent_t    q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  output bbf_pkg::result_t out_data_o,
  input  logic             out_ready_i
);

  localparam int SC   = SOURCE_COUNT;
  localparam int CB   = BEAT_COUNT_BITS;
  localparam int AW   = bbf_pkg::ADDR_BITS;
  localparam int SW   = (SC > 1) ? $clog2(SC) : 1;
  localparam int IDW  = bbf_pkg::SRC_ID_W + 3;
  localparam int ZW   = bbf_pkg::SIZE_W + 1;
  localparam int CLOG2_BUS = $clog2(BUS_BYTES);
  // byte offset lost when the beat offset wraps
  localparam logic [AW-1:0] WRAP_BYTES = AW'(64'(BUS_BYTES) << CB);

  logic [SC-1:0]      free_q, free_d;
  logic [CB-1:0]      beat_q, beat_d;
  logic [AW-1:0]      byte_q, byte_d;   // beat_q * BUS_BYTES, kept incrementally
  bbf_pkg::cfg_t      log2_q;
  logic               out_valid_q;
  bbf_pkg::result_t   out_q;

  logic [SC-1:0]      iso, rel_mask;
  logic [SW-1:0]      lowest;
  logic               any_free, issue, transfer, hit, step_ok, pop;
  logic [CB:0]        beat_sum;
  logic [CB-1:0]      step_beats;
  logic [AW-1:0]      step_bytes;
  logic [ZW-1:0]      size_sum;
  bbf_pkg::result_t   res;

  assign pop     = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;

  always_comb begin
    iso      = free_q & (~free_q + 1'b1);
    any_free = |free_q;
    lowest   = '0;
    rel_mask = '0;
    for (int i = 0; i < SC; i++) begin
      lowest      = lowest | (SW'(i) & {SW{iso[i]}});
      rel_mask[i] = q_data_i.rel_valid && (IDW'(q_data_i.rel_id) == IDW'(i));
    end
  end

  always_comb begin
    issue      = q_data_i.issue && any_free;
    transfer   = issue && q_data_i.req_ready;
    step_ok    = int'(log2_q) < CB;
    step_beats = step_ok ? (CB'(1) << log2_q) : '0;
    step_bytes = step_ok ? (AW'(BUS_BYTES) << log2_q) : '0;
    beat_sum   = {1'b0, beat_q} + {1'b0, step_beats};
    hit        = beat_sum[CB-1:0] == CB'(q_data_i.cmd_beats);
    size_sum   = {1'b0, log2_q} + ZW'(CLOG2_BUS);

    res.req_valid     = issue;
    res.req_address   = q_data_i.cmd_address + byte_q;
    res.req_source    = bbf_pkg::SRC_ID_W'(lowest);
    res.req_size_log2 = (size_sum > ZW'(bbf_pkg::SIZE_MAX)) ? bbf_pkg::SIZE_MAX
                                                            : size_sum[ZW-2:0];
    res.cmd_ready     = transfer && hit;

    free_d = free_q | rel_mask;
    beat_d = beat_q;
    byte_d = byte_q;
    if (transfer) begin
      free_d = free_d & ~iso;   // claim beats a free of the same ID
      if (hit) begin
        beat_d = '0;
        byte_d = '0;
      end else begin
        beat_d = beat_sum[CB-1:0];
        byte_d = byte_q + step_bytes - (beat_sum[CB] ? WRAP_BYTES : '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '1;
      beat_q      <= '0;
      byte_q      <= '0;
      log2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        log2_q <= cfg_data_i;
      end
      if (pop) begin
        free_q      <= free_d;
        beat_q      <= beat_d;
        byte_q      <= byte_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_byte_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_q == AW'(64'(beat_q) * 64'(BUS_BYTES)))
    else $error("byte offset out of step with beat offset");

  a_claim_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && transfer) |=> ((free_q & $past(iso)) == '0))
    else $error("claimed source still free");

  a_ack_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res.cmd_ready) |=> (beat_q == '0))
    else $error("offset not cleared after command done");

  a_ack_needs_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.cmd_ready || out_q.req_valid))
    else $error("command acknowledged without a request");

endmodule
